### design/pid_position_or_delta_core_defines.svh
// assertion macros for the pid position/delta core
// used by the core top level; needs clk_i and rst_ni in the including module
`ifndef PID_POSITION_OR_DELTA_CORE_DEFINES_SVH
`define PID_POSITION_OR_DELTA_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define PIDPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked check that also holds during reset
`define PIDPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PIDPD_ASSERT(lbl, prop, msg)
`define PIDPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/pidpd_pkg.sv
// shared types, register codes and the saturation helper of the pid core
// no dependencies
package pidpd_pkg;

  localparam int unsigned QSHIFT  = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ERR_W   = SAMPLE_W + 1;
  localparam int unsigned LIMIT_W = 31;
  localparam int unsigned DRIVE_W = 32;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_KP        = 3'd1,
    REG_KI        = 3'd2,
    REG_KD        = 3'd3,
    REG_MAX_OUT   = 3'd4,
    REG_MAX_INTEG = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } pid_mode_e;

  typedef struct packed {
    pid_mode_e                 mode;
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic        [LIMIT_W-1:0] max_out;
    logic        [LIMIT_W-1:0] max_integ;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DRIVE_W-1:0] integral;
    logic signed [DRIVE_W-1:0] drive;
  } step_t;

  // symmetric saturation to +-m
  function automatic logic signed [DRIVE_W-1:0] sat(input logic signed [SUM_W-1:0] x,
                                                    input logic [LIMIT_W-1:0] m);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] r;
    hi = $signed({{(SUM_W-LIMIT_W){1'b0}}, m});
    lo = -hi;
    if (x > hi) r = hi;
    else if (x < lo) r = lo;
    else r = x;
    return r[DRIVE_W-1:0];
  endfunction

endpackage

### design/pidpd_calc.sv
// one pid update: error, three gain products, integral clamp (positional mode) and output clamp
// depends on pidpd_pkg
module pidpd_calc import pidpd_pkg::*; (
  input  cfg_t                      cfg_i,
  input  logic signed [SAMPLE_W-1:0] feedback_i,
  input  logic signed [SAMPLE_W-1:0] setpoint_i,
  input  logic signed [ERR_W-1:0]   err1_i,
  input  logic signed [ERR_W-1:0]   err2_i,
  input  logic signed [DRIVE_W-1:0] integral_i,
  input  logic signed [DRIVE_W-1:0] held_i,
  output step_t                     step_o
);

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W:0]     d1;      // e - e1
  logic signed [ERR_W+1:0]   d2;      // e - 2*e1 + e2
  logic signed [ERR_W:0]     p_op;
  logic signed [ERR_W+1:0]   d_op;
  logic signed [GAIN_W+ERR_W:0]   p_prod;
  logic signed [GAIN_W+ERR_W-1:0] i_prod;
  logic signed [GAIN_W+ERR_W+1:0] d_prod;
  logic signed [GAIN_W+ERR_W-QSHIFT:0]   p_term;
  logic signed [GAIN_W+ERR_W-QSHIFT-1:0] i_term;
  logic signed [GAIN_W+ERR_W-QSHIFT+1:0] d_term;
  logic signed [SUM_W-1:0]   int_sum;
  logic signed [DRIVE_W-1:0] int_sat;
  logic signed [SUM_W-1:0]   base;
  logic signed [SUM_W-1:0]   i_add;
  logic signed [SUM_W-1:0]   y_sum;
  logic                      incr;

  assign incr = (cfg_i.mode == MODE_INCREMENTAL);

  assign err = ERR_W'(setpoint_i) - ERR_W'(feedback_i);
  assign d1  = (ERR_W+1)'(err) - (ERR_W+1)'(err1_i);
  assign d2  = (ERR_W+2)'(err) - ((ERR_W+2)'(err1_i) <<< 1) + (ERR_W+2)'(err2_i);

  // proportional and derivative multipliers take the differenced error in delta mode
  assign p_op = incr ? d1 : (ERR_W+1)'(err);
  assign d_op = incr ? d2 : (ERR_W+2)'(d1);

  assign p_prod = (GAIN_W+ERR_W+1)'(cfg_i.kp) * (GAIN_W+ERR_W+1)'(p_op);
  assign i_prod = (GAIN_W+ERR_W)'(cfg_i.ki) * (GAIN_W+ERR_W)'(err);
  assign d_prod = (GAIN_W+ERR_W+2)'(cfg_i.kd) * (GAIN_W+ERR_W+2)'(d_op);

  // dropping the low bits is a floor shift
  assign p_term = p_prod[GAIN_W+ERR_W:QSHIFT];
  assign i_term = i_prod[GAIN_W+ERR_W-1:QSHIFT];
  assign d_term = d_prod[GAIN_W+ERR_W+1:QSHIFT];

  assign int_sum = SUM_W'(integral_i) + SUM_W'(i_term);
  assign int_sat = sat(int_sum, cfg_i.max_integ);

  assign base  = incr ? SUM_W'(held_i) : SUM_W'(int_sat);
  assign i_add = incr ? SUM_W'(i_term) : '0;
  assign y_sum = base + SUM_W'(p_term) + i_add + SUM_W'(d_term);

  assign step_o.err      = err;
  assign step_o.integral = incr ? DRIVE_W'(i_term) : int_sat;
  assign step_o.drive    = sat(y_sum, cfg_i.max_out);

endmodule

### design/pid_position_or_delta_core.sv
// top level of the positional / incremental pid core
// depends on pidpd_pkg, pidpd_calc and pid_position_or_delta_core_defines.svh

// usage
//   input channel: feedback_i and setpoint_i, one word per sample, in_valid_i / in_stall_o
//   output channel: drive_o, one word per sample, out_valid_o / out_stall_i
//   a word moves at a clock edge with valid high and stall low
//   registers (apb, byte address 4*i): mode, kp, ki, kd, max_out, max_integ;
//   write them only while no sample is in flight
//   path: an accepted word is held in the input register, then its update is
//   written into the drive register, which feeds drive_o
//   throughput: one sample per cycle while out_stall_i is low; the whole
//   update is one pass of three multipliers plus two clamped adds between
//   the input register and the drive register
//   stall: the drive register holds its word; the input register still takes
//   one more sample, then in_stall_o rises until the drive word is taken
//   reset: registers, error history, integral and held drive clear to zero,
//   both channels come up empty
`include "pid_position_or_delta_core_defines.svh"

module pid_position_or_delta_core import pidpd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input samples
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] feedback_i,
  input  logic signed [SAMPLE_W-1:0] setpoint_i,
  // drive output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DRIVE_W-1:0]  drive_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  // configuration registers
  cfg_t cfg_q;
  logic cfg_wr;
  cfg_idx_e cfg_idx;

  // input stage
  logic                       s1_valid_q;
  logic signed [SAMPLE_W-1:0] fb_q;
  logic signed [SAMPLE_W-1:0] sp_q;

  // controller state; held_q doubles as the drive register
  logic                       out_valid_q;
  logic signed [ERR_W-1:0]    err1_q;
  logic signed [ERR_W-1:0]    err2_q;
  logic signed [DRIVE_W-1:0]  integ_q;
  logic signed [DRIVE_W-1:0]  held_q;

  logic  in_take;
  logic  adv;
  step_t step;

  // register port, zero wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:      cfg_q.mode      <= pid_mode_e'(pwdata[0]);
        REG_KP:        cfg_q.kp        <= pwdata[GAIN_W-1:0];
        REG_KI:        cfg_q.ki        <= pwdata[GAIN_W-1:0];
        REG_KD:        cfg_q.kd        <= pwdata[GAIN_W-1:0];
        REG_MAX_OUT:   cfg_q.max_out   <= pwdata[LIMIT_W-1:0];
        REG_MAX_INTEG: cfg_q.max_integ <= pwdata[LIMIT_W-1:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  // read mux, gains read back sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_MODE:      prdata = DATA_W'(cfg_q.mode);
      REG_KP:        prdata = DATA_W'(cfg_q.kp);
      REG_KI:        prdata = DATA_W'(cfg_q.ki);
      REG_KD:        prdata = DATA_W'(cfg_q.kd);
      REG_MAX_OUT:   prdata = DATA_W'(cfg_q.max_out);
      REG_MAX_INTEG: prdata = DATA_W'(cfg_q.max_integ);
      default:       prdata = '0;
    endcase
  end

  // handshake: the input stage moves on whenever the drive register is free
  // or being emptied this cycle
  assign adv        = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_take || (s1_valid_q && !adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      fb_q <= feedback_i;
      sp_q <= setpoint_i;
    end
  end

  // the full update for one sample
  pidpd_calc u_calc (
    .cfg_i      (cfg_q),
    .feedback_i (fb_q),
    .setpoint_i (sp_q),
    .err1_i     (err1_q),
    .err2_i     (err2_q),
    .integral_i (integ_q),
    .held_i     (held_q),
    .step_o     (step)
  );

  // state and drive register update together, so the next sample sees them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      err1_q      <= '0;
      err2_q      <= '0;
      integ_q     <= '0;
      held_q      <= '0;
    end else begin
      out_valid_q <= adv || (out_valid_q && out_stall_i);
      if (adv) begin
        err2_q  <= err1_q;
        err1_q  <= step.err;
        integ_q <= step.integral;
        held_q  <= step.drive;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = held_q;

  // checks
  `PIDPD_ASSERT_ALWAYS(a_stall_only_when_full,
    in_stall_o |-> (s1_valid_q && out_valid_q), "input stalled with a free stage")
  `PIDPD_ASSERT(a_adv_fills_out,
    adv |=> out_valid_q, "advanced sample did not reach the drive register")
  `PIDPD_ASSERT(a_history_shift,
    adv |=> (err2_q == $past(err1_q)), "error history did not shift")
  `PIDPD_ASSERT(a_state_hold,
    !adv |=> ($stable(held_q) && $stable(integ_q) && $stable(err1_q)),
    "controller state changed without a sample")

endmodule

### tb/pid_position_or_delta_core_checker.sv
// drive checker for the pid position/delta core: watches both word channels
// and register writes, predicts each drive word and compares; needs pidpd_pkg
module pid_position_or_delta_core_checker import pidpd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [SAMPLE_W-1:0] feedback_i,
  input  logic signed [SAMPLE_W-1:0] setpoint_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [DRIVE_W-1:0]  drive_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [ADDR_W-1:0]          paddr_i,
  input  logic [DATA_W-1:0]          pwdata_i,
  input  logic                       pready_i,
  output int unsigned                words_due_o,
  output int unsigned                mismatches_o
);

  cfg_t                      cfg_q;
  logic signed [ERR_W-1:0]   err1_q;
  logic signed [ERR_W-1:0]   err2_q;
  logic signed [DRIVE_W-1:0] integ_q;
  logic signed [DRIVE_W-1:0] held_q;
  logic signed [DRIVE_W-1:0] drive_due[$];

  function automatic longint floor_q8(input longint x);
    return x >>> QSHIFT;
  endfunction

  function automatic longint clamp_sym(input longint x, input longint m);
    if (x > m) return m;
    if (x < -m) return -m;
    return x;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t drive check: %s", $time, what);
    mismatches_o++;
  endtask

  // one control step, updates the history and queues the drive word
  task automatic predict_drive(input logic signed [SAMPLE_W-1:0] fb,
                               input logic signed [SAMPLE_W-1:0] sp);
    longint e, e1, e2, kp, ki, kd, p, i, d, y, integ;
    e  = longint'(sp) - longint'(fb);
    e1 = longint'(err1_q);
    e2 = longint'(err2_q);
    kp = longint'($signed(cfg_q.kp));
    ki = longint'($signed(cfg_q.ki));
    kd = longint'($signed(cfg_q.kd));
    if (cfg_q.mode == MODE_POSITIONAL) begin
      p = floor_q8(kp * e);
      integ = clamp_sym(longint'(integ_q) + floor_q8(ki * e), longint'(cfg_q.max_integ));
      d = floor_q8(kd * (e - e1));
      y = clamp_sym(p + integ + d, longint'(cfg_q.max_out));
    end else begin
      // integral is reloaded, not accumulated
      p = floor_q8(kp * (e - e1));
      i = floor_q8(ki * e);
      integ = i;
      d = floor_q8(kd * (e - 2 * e1 + e2));
      y = clamp_sym(longint'(held_q) + p + i + d, longint'(cfg_q.max_out));
    end
    integ_q = integ[DRIVE_W-1:0];
    held_q  = y[DRIVE_W-1:0];
    err2_q  = err1_q;
    err1_q  = e[ERR_W-1:0];
    drive_due.push_back(y[DRIVE_W-1:0]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [DRIVE_W-1:0] want;
    if (!rst_ni) begin
      cfg_q        = '0;
      err1_q       = '0;
      err2_q       = '0;
      integ_q      = '0;
      held_q       = '0;
      drive_due    = {};
      words_due_o  = 0;
      mismatches_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_idx_e'(paddr_i[ADDR_W-1:2]))
          REG_MODE:      cfg_q.mode      = pid_mode_e'(pwdata_i[0]);
          REG_KP:        cfg_q.kp        = pwdata_i[GAIN_W-1:0];
          REG_KI:        cfg_q.ki        = pwdata_i[GAIN_W-1:0];
          REG_KD:        cfg_q.kd        = pwdata_i[GAIN_W-1:0];
          REG_MAX_OUT:   cfg_q.max_out   = pwdata_i[LIMIT_W-1:0];
          REG_MAX_INTEG: cfg_q.max_integ = pwdata_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (drive_due.size() == 0) begin
          report_mismatch($sformatf("drive word %0d with no sample pending", drive_i));
        end else begin
          want = drive_due.pop_front();
          if (drive_i !== want)
            report_mismatch($sformatf("drive %0d, predicted %0d", drive_i, want));
        end
      end
      if (in_valid_i && !in_stall_i) predict_drive(feedback_i, setpoint_i);
      words_due_o = drive_due.size();
    end
  end

endmodule

### tb/pid_position_or_delta_core_test.sv
// top of the pid position/delta core test: clock, reset, register writes,
// sample stimulus and the verdict; needs pidpd_pkg, the core and its checker
module pid_position_or_delta_core_test;
  import pidpd_pkg::*;

  // register indexes past the last register, writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int         RAND_PHASES  = 10;
  localparam int         PHASE_WORDS  = 150;
  localparam int         HOLD_CYCLES  = 300;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] feedback_i;
  logic signed [SAMPLE_W-1:0] setpoint_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [DRIVE_W-1:0]  drive_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  int unsigned words_due;
  int unsigned mismatches;

  // knobs set by the sender (main process); stall_pct and hold_req are read by the receiver process
  int send_idle_pct;
  int stall_pct;
  bit hold_req;

  pid_position_or_delta_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .feedback_i  (feedback_i),
    .setpoint_i  (setpoint_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // the checker sits beside the core and sees exactly what the core sees
  pid_position_or_delta_core_checker drive_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .feedback_i   (feedback_i),
    .setpoint_i   (setpoint_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_i      (drive_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .words_due_o  (words_due),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("pid_position_or_delta_core_test: done, errors");
    $finish;
  end

  // receiver: random stall per cycle, or a long hold-off counted down here
  initial begin
    int hold_left;
    bit hold_used;
    out_stall_i = 1'b0;
    hold_left   = 0;
    hold_used   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer one sample word, with random idle cycles first, and wait for accept
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] fb,
                              input logic signed [SAMPLE_W-1:0] sp);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    feedback_i <= fb;
    setpoint_i <= sp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop sending and let every predicted drive word come out,
  // then let the two-stage pipe empty
  task automatic drain_core();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (words_due == 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(3))
      0:       return GAIN_W'($urandom);
      1:       return GAIN_W'($urandom_range(2048) - 1024);
      2:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'h0200;  // 2.0 in q8.8
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] random_limit();
    case ($urandom_range(3))
      0:       return '0;
      1:       return LIMIT_W'($urandom_range(5000, 1));
      2:       return LIMIT_W'($urandom);
      default: return 31'h7fffffff;
    endcase
  endfunction

  initial begin
    int                         phase;
    int                         n;
    int                         target;
    logic signed [SAMPLE_W-1:0] fb_v;
    logic signed [SAMPLE_W-1:0] sp_v;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    feedback_i    = '0;
    setpoint_i    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset config has both limits at zero, so drive must stay zero
    offer_sample(16'sh7fff, -16'sh8000);
    offer_sample(-16'sh8000, 16'sh7fff);
    drain_core();

    // unit-ish gains, widest limits, error extremes and floor on negatives
    write_reg(REG_MODE, DATA_W'(MODE_POSITIONAL));
    write_reg(REG_KP, 32'h0000_0100);
    write_reg(REG_KI, 32'h0000_0080);
    write_reg(REG_KD, 32'h0000_0040);
    write_reg(REG_MAX_OUT, 32'h7fff_ffff);
    write_reg(REG_MAX_INTEG, 32'h7fff_ffff);
    offer_sample(16'sd0, 16'sd100);
    offer_sample(16'sd0, 16'sd100);
    offer_sample(16'sh7fff, -16'sh8000);
    offer_sample(-16'sh8000, 16'sh7fff);
    offer_sample(-16'sd1, 16'sd0);
    drain_core();

    // extreme gains against extreme errors
    write_reg(REG_KP, 32'hffff_8000);
    write_reg(REG_KI, 32'h0000_7fff);
    write_reg(REG_KD, 32'hffff_8000);
    offer_sample(-16'sh8000, 16'sh7fff);
    offer_sample(16'sh7fff, -16'sh8000);
    offer_sample(16'sd0, 16'sd0);
    drain_core();

    // tighter limits on a running integral take effect at the next clamp
    write_reg(REG_MAX_OUT, 32'd1000);
    write_reg(REG_MAX_INTEG, 32'd500);
    offer_sample(16'sd0, 16'sd300);
    offer_sample(16'sd0, 16'sd300);
    offer_sample(16'sd0, -16'sd300);
    drain_core();

    // incremental mode reloads the integral, positional then carries on from it
    write_reg(REG_MODE, DATA_W'(MODE_INCREMENTAL));
    offer_sample(16'sd10, 16'sd20);
    offer_sample(-16'sh8000, 16'sh7fff);
    offer_sample(16'sh7fff, -16'sh8000);
    offer_sample(16'sd5, 16'sd5);
    drain_core();
    write_reg(REG_MODE, DATA_W'(MODE_POSITIONAL));
    offer_sample(16'sd5, 16'sd5);
    drain_core();

    // writes past the last register change nothing
    write_reg(REG_SPARE_LO, 32'hffff_ffff);
    write_reg(REG_SPARE_HI, 32'hffff_ffff);
    offer_sample(16'sd1, 16'sd2);
    offer_sample(16'sd2, 16'sd1);
    drain_core();

    // random phases: fresh settings, a mostly tracking loop with some noise,
    // and the idling pattern rotating through the four mixes
    target = 0;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      write_reg(REG_MODE, DATA_W'($urandom_range(1) ? MODE_INCREMENTAL : MODE_POSITIONAL));
      write_reg(REG_KP, DATA_W'($signed(random_gain())));
      write_reg(REG_KI, DATA_W'($signed(random_gain())));
      write_reg(REG_KD, DATA_W'($signed(random_gain())));
      write_reg(REG_MAX_OUT, DATA_W'(random_limit()));
      write_reg(REG_MAX_INTEG, DATA_W'(random_limit()));
      case (phase % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 69; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      // long hold-off while the sender keeps pushing, fills the pipe
      if (phase == 4) hold_req = 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(19) == 0) target = int'($urandom_range(64000)) - 32000;
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: begin
            sp_v = SAMPLE_W'(target);
            fb_v = SAMPLE_W'(target + int'($urandom_range(400)) - 200);
          end
          6, 7, 8: begin
            sp_v = SAMPLE_W'($urandom);
            fb_v = SAMPLE_W'($urandom);
          end
          default: begin
            fb_v = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
            sp_v = $urandom_range(1) ? -fb_v - 16'sd1 : SAMPLE_W'($urandom);
          end
        endcase
        offer_sample(fb_v, sp_v);
      end
      drain_core();
    end

    // nothing outstanding; give any stray word time to show up
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("pid_position_or_delta_core_test: done, clean");
    end else begin
      $display("pid_position_or_delta_core_test: done, errors");
    end
    $finish;
  end

endmodule
